// ===== src/gspa_pkg.sv =====
// gspa_pkg: shared constants, types and helpers of the grid square placement allocator
// used by gspa_row_unit and grid_square_placement_allocator; no dependencies
package gspa_pkg;

	localparam int GRID  = 64;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;

	localparam logic [CNT_W-1:0] GRID_C = CNT_W'(GRID);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DROP1,
		ST_UNION,
		ST_SLIDE,
		ST_DROP2,
		ST_MARK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic            hit;
		logic [GRID-1:0] row;
		logic [GRID-1:0] merged;
	} row_chk_t;

	// run of s ones starting at column col
	function automatic logic [GRID-1:0] span_mask(logic [CNT_W-1:0] s, logic [IDX_W-1:0] col);
		logic [GRID-1:0] ones;
		if (s >= GRID_C) begin
			ones = '1;
		end else begin
			ones = (GRID'(1) << s) - GRID'(1);
		end
		return ones << col;
	endfunction

endpackage

// ===== src/gspa_ram.sv =====
// gspa_ram: generic single write port, single read port ram with registered read
// no dependencies
module gspa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/gspa_row_unit.sv =====
// gspa_row_unit: shared row check unit, collision test and merge of one occupancy row
// depends on gspa_pkg
module gspa_row_unit (
	input  logic [gspa_pkg::GRID-1:0] rd_data,
	input  logic                      rd_valid,
	input  logic [gspa_pkg::GRID-1:0] mask,
	output gspa_pkg::row_chk_t        chk
);

	logic [gspa_pkg::GRID-1:0] row;

	// never written rows read as free
	assign row        = rd_valid ? rd_data : '0;
	assign chk.row    = row;
	assign chk.hit    = |(row & mask);
	assign chk.merged = row | mask;

endmodule

// ===== src/grid_square_placement_allocator.sv =====
// grid_square_placement_allocator: places squares into a 64 x 64 occupancy grid
// depends on gspa_pkg, gspa_ram, gspa_row_unit
//
// channel   ports                          handshake
// input     side                           start && !busy
// result    placed, bottom_row, left_col   done, one cycle, no stall
//
// one row is read from the grid ram per cycle; every step is a row or bit scan
// steps in order: first drop, union of the rows under the square, slide left, second drop, mark;
//   a failed first drop and a bad side both go straight to done
// reset clears per-row valid bits at once, no clearing pass
// the receiver cannot stall: done is high for exactly one cycle, then busy falls
module grid_square_placement_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [gspa_pkg::CNT_W-1:0]   side,
	output logic                         done,
	output logic                         placed,
	output logic [gspa_pkg::IDX_W-1:0]   bottom_row,
	output logic [gspa_pkg::IDX_W-1:0]   left_col
);

	gspa_pkg::state_t state_q, state_d;

	logic [gspa_pkg::CNT_W-1:0] s_q;
	logic [gspa_pkg::GRID-1:0]  mask_q;
	logic [gspa_pkg::IDX_W-1:0] col_q;
	logic [gspa_pkg::IDX_W-1:0] bottom_q;
	logic                       placed_q;
	logic [gspa_pkg::GRID-1:0]  u_q;
	logic [gspa_pkg::CNT_W-1:0] ra_q;
	logic [gspa_pkg::IDX_W-1:0] cc_q;
	logic [gspa_pkg::GRID-1:0]  rowv_q;

	logic                       rvalid_s1;
	logic [gspa_pkg::IDX_W-1:0] raddr_s1;
	logic                       vbit_s1;

	logic [gspa_pkg::GRID-1:0]  rd_data;
	gspa_pkg::row_chk_t         chk;

	logic                       issue;
	logic                       scan_end;
	logic                       slide_end;
	logic                       we;
	logic                       side_bad;
	logic [gspa_pkg::CNT_W-1:0] f_row;
	logic                       drop_fail;
	logic [gspa_pkg::IDX_W-1:0] new_bottom;
	logic [gspa_pkg::IDX_W-1:0] fin_bottom;
	logic [gspa_pkg::CNT_W-1:0] win_top;
	logic [gspa_pkg::IDX_W-1:0] cc_m1;

	gspa_ram #(
		.WIDTH(gspa_pkg::GRID),
		.DEPTH(gspa_pkg::GRID)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(raddr_s1),
		.wdata(chk.merged),
		.raddr(ra_q[gspa_pkg::IDX_W-1:0]),
		.rdata(rd_data)
	);

	gspa_row_unit u_row (
		.rd_data (rd_data),
		.rd_valid(vbit_s1),
		.mask    (mask_q),
		.chk     (chk)
	);

	assign side_bad   = (side == '0) || (side > gspa_pkg::GRID_C);
	assign f_row      = chk.hit ? {1'b0, raddr_s1} : gspa_pkg::GRID_C;
	assign drop_fail  = f_row < s_q;
	assign new_bottom = gspa_pkg::IDX_W'(f_row - gspa_pkg::CNT_W'(1));
	assign fin_bottom = (state_q == gspa_pkg::ST_DROP2 && drop_fail) ? bottom_q : new_bottom;
	assign win_top    = {1'b0, fin_bottom} + gspa_pkg::CNT_W'(1) - s_q;
	assign cc_m1      = cc_q - gspa_pkg::IDX_W'(1);

	// control outputs
	always_comb begin
		issue     = 1'b0;
		scan_end  = 1'b0;
		slide_end = 1'b0;
		we        = 1'b0;
		unique case (state_q)
			gspa_pkg::ST_DROP1, gspa_pkg::ST_DROP2: begin
				scan_end = rvalid_s1 &&
					(chk.hit || raddr_s1 == gspa_pkg::IDX_W'(gspa_pkg::GRID - 1));
				issue    = (ra_q < gspa_pkg::GRID_C) && !scan_end;
			end
			gspa_pkg::ST_UNION: begin
				scan_end = rvalid_s1 && (raddr_s1 == bottom_q);
				issue    = (ra_q <= {1'b0, bottom_q}) && !scan_end;
			end
			gspa_pkg::ST_MARK: begin
				scan_end = rvalid_s1 && (raddr_s1 == bottom_q);
				issue    = (ra_q <= {1'b0, bottom_q}) && !scan_end;
				we       = rvalid_s1;
			end
			gspa_pkg::ST_SLIDE: begin
				slide_end = (cc_q == '0) || u_q[cc_m1];
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gspa_pkg::ST_IDLE: begin
				if (start) begin
					state_d = side_bad ? gspa_pkg::ST_DONE : gspa_pkg::ST_DROP1;
				end
			end
			gspa_pkg::ST_DROP1: begin
				if (scan_end) begin
					state_d = drop_fail ? gspa_pkg::ST_DONE : gspa_pkg::ST_UNION;
				end
			end
			gspa_pkg::ST_UNION: begin
				if (scan_end) begin
					state_d = gspa_pkg::ST_SLIDE;
				end
			end
			gspa_pkg::ST_SLIDE: begin
				if (slide_end) begin
					state_d = gspa_pkg::ST_DROP2;
				end
			end
			gspa_pkg::ST_DROP2: begin
				if (scan_end) begin
					state_d = gspa_pkg::ST_MARK;
				end
			end
			gspa_pkg::ST_MARK: begin
				if (scan_end) begin
					state_d = gspa_pkg::ST_DONE;
				end
			end
			gspa_pkg::ST_DONE: begin
				state_d = gspa_pkg::ST_IDLE;
			end
			default: begin
				state_d = gspa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= gspa_pkg::ST_IDLE;
			rvalid_s1 <= 1'b0;
			rowv_q    <= '0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= issue;
			if (we) begin
				rowv_q[raddr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= ra_q[gspa_pkg::IDX_W-1:0];
		vbit_s1  <= rowv_q[ra_q[gspa_pkg::IDX_W-1:0]];
		if (issue) begin
			ra_q <= ra_q + gspa_pkg::CNT_W'(1);
		end
		unique case (state_q)
			gspa_pkg::ST_IDLE: begin
				if (start) begin
					s_q      <= side;
					col_q    <= gspa_pkg::IDX_W'(gspa_pkg::GRID_C - side);
					mask_q   <= gspa_pkg::span_mask(side,
						gspa_pkg::IDX_W'(gspa_pkg::GRID_C - side));
					ra_q     <= '0;
					placed_q <= 1'b0;
				end
			end
			gspa_pkg::ST_DROP1: begin
				if (scan_end && !drop_fail) begin
					bottom_q <= new_bottom;
					ra_q     <= win_top;
					u_q      <= '0;
				end
			end
			gspa_pkg::ST_UNION: begin
				if (rvalid_s1) begin
					u_q <= u_q | chk.row;
				end
				if (scan_end) begin
					cc_q <= col_q;
				end
			end
			gspa_pkg::ST_SLIDE: begin
				if (slide_end) begin
					col_q  <= cc_q;
					mask_q <= gspa_pkg::span_mask(s_q, cc_q);
					ra_q   <= '0;
				end else begin
					cc_q <= cc_m1;
				end
			end
			gspa_pkg::ST_DROP2: begin
				if (scan_end) begin
					bottom_q <= fin_bottom;
					ra_q     <= win_top;
				end
			end
			gspa_pkg::ST_MARK: begin
				if (scan_end) begin
					placed_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy       = state_q != gspa_pkg::ST_IDLE;
	assign done       = state_q == gspa_pkg::ST_DONE;
	assign placed     = placed_q;
	assign bottom_row = placed_q ? bottom_q : '0;
	assign left_col   = placed_q ? col_q : '0;

	// grid is written only while marking
	a_we_mark: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == gspa_pkg::ST_MARK)
		else $error("grid write outside mark phase");

	// accepted word makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not start work");

	// result strobe lasts one cycle
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("result strobe held or block stuck");

	// placed square lies inside the grid
	a_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && placed) |->
			(({1'b0, bottom_row} + gspa_pkg::CNT_W'(1)) >= s_q) &&
			(({1'b0, left_col} + s_q) <= gspa_pkg::GRID_C))
		else $error("placed square outside grid");

endmodule
